// File: hdl/ufs_pkg.sv
// ----------------------------------------------------------------------------
// ufs_pkg: shared types and constants of the urlencoded form splitter
// Result kinds, the command word passed from front to back, and hex decode.
// ----------------------------------------------------------------------------
package ufs_pkg;

  // result kinds
  localparam logic [1:0] KindName  = 2'd0;
  localparam logic [1:0] KindValue = 2'd1;
  localparam logic [1:0] KindEnd   = 2'd2;

  // characters of the urlencoded syntax
  localparam logic [7:0] ChEq    = 8'h3D;  // '='
  localparam logic [7:0] ChAmp   = 8'h26;  // '&'
  localparam logic [7:0] ChPlus  = 8'h2B;  // '+'
  localparam logic [7:0] ChPct   = 8'h25;  // '%'
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic [7:0] MaxFieldsRst = 8'd64;

  // one classified input byte: an optional first result, then an optional
  // field end caused by end of data
  typedef struct packed {
    logic       r0_v;
    logic [1:0] r0_kind;
    logic [7:0] r0_byte;
    logic       end_v;
    logic [7:0] index;
  } cmd_t;

  // anything that is not a hex digit decodes as zero
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

// File: hdl/urlencoded_form_splitter_core.sv
// ----------------------------------------------------------------------------
// urlencoded_form_splitter_core: streaming urlencoded form splitter
// Splits posted form bytes into name bytes, decoded value bytes and field
// end markers, each tagged with its field number.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  input    | in_valid_i / in_stall_o | data_byte_i, end_of_data_i
//  output   | out_valid_o/out_stall_i | kind_o, out_byte_o, field_index_o,
//           |                         | run_last_o
//  config   | cfg_we_i                | cfg_wdata_i (max_fields)
//
//  One input beat per cycle while in_stall_o is low. A byte yields zero,
//  one or two output beats; the output register drains one beat per cycle
//  unless out_stall_i is high, and the command queue soaks up a byte with
//  two results. The first result of a byte is registered in the command
//  queue, then in the output register. in_stall_o rises only when the
//  command queue is full. Reset (rst_ni low, asynchronous) clears parse
//  state, the queue and the output valid, and sets max_fields to 64.
// ----------------------------------------------------------------------------
module urlencoded_form_splitter_core #(
  parameter int QueueDepth = 2  // command queue entries, 2 or more
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // input beats
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_data_i,
  // output beats
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] field_index_o,
  output logic       run_last_o
);

  ufs_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, q_full, q_empty;

  // front: parse state machine, field counter and limit register
  ufs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .end_of_data_i (end_of_data_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  // bytes that cause no result are never queued
  ufs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: one output beat per cycle from the queue head, unless out_stall_i holds it
  ufs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (head_cmd),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .field_index_o (field_index_o),
    .run_last_o    (run_last_o)
  );

endmodule

// File: hdl/ufs_front.sv
// ----------------------------------------------------------------------------
// ufs_front: byte classifier
// Holds the parse state and the field limit, turns each byte into a command.
// ----------------------------------------------------------------------------
module ufs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_data_i,
  input  logic            q_full_i,
  output logic            push_o,
  output ufs_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] PhBetween = 3'd0;
  localparam logic [2:0] PhName    = 3'd1;
  localparam logic [2:0] PhValue   = 3'd2;
  localparam logic [2:0] PhEsc1    = 3'd3;
  localparam logic [2:0] PhEsc2    = 3'd4;
  localparam logic [2:0] PhDrop    = 3'd5;

  logic [2:0] phase_q, phase_d, phase_eff;
  logic [3:0] nib_q, nib_d;
  logic [7:0] opened_q, opened_d, opened_eff;
  logic [7:0] max_fields_q;
  logic       accept;
  ufs_pkg::cmd_t cmd;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fields_q <= ufs_pkg::MaxFieldsRst;
    end else if (cfg_we_i) begin
      max_fields_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    opened_eff = opened_q;
    phase_eff  = phase_q;
    if (phase_q == PhBetween) begin
      if (opened_q < max_fields_q) begin
        opened_eff = opened_q + 8'd1;
        phase_eff  = PhName;
      end else begin
        phase_eff = PhDrop;
      end
    end

    phase_d     = phase_eff;
    nib_d       = nib_q;
    opened_d    = opened_eff;
    cmd.r0_v    = 1'b0;
    cmd.r0_kind = ufs_pkg::KindValue;
    cmd.r0_byte = data_byte_i;
    cmd.end_v   = 1'b0;
    cmd.index   = opened_eff - 8'd1;

    case (phase_eff)
      PhName: begin
        if (data_byte_i == ufs_pkg::ChEq) begin
          phase_d = PhValue;
        end else begin
          cmd.r0_v    = 1'b1;
          cmd.r0_kind = ufs_pkg::KindName;
        end
      end
      PhValue: begin
        if (data_byte_i == ufs_pkg::ChAmp) begin
          cmd.r0_v    = 1'b1;
          cmd.r0_kind = ufs_pkg::KindEnd;
          cmd.r0_byte = 8'd0;
          phase_d     = PhBetween;
        end else if (data_byte_i == ufs_pkg::ChPlus) begin
          cmd.r0_v    = 1'b1;
          cmd.r0_byte = ufs_pkg::ChSpace;
        end else if (data_byte_i == ufs_pkg::ChPct) begin
          phase_d = PhEsc1;
        end else begin
          cmd.r0_v = 1'b1;
        end
      end
      PhEsc1: begin
        if (data_byte_i == ufs_pkg::ChAmp) begin
          cmd.r0_v    = 1'b1;
          cmd.r0_kind = ufs_pkg::KindEnd;
          cmd.r0_byte = 8'd0;
          phase_d     = PhBetween;
        end else begin
          nib_d   = ufs_pkg::hex_digit(data_byte_i);
          phase_d = PhEsc2;
        end
      end
      PhEsc2: begin
        cmd.r0_v = 1'b1;
        nib_d    = 4'd0;
        if (data_byte_i == ufs_pkg::ChAmp) begin
          cmd.r0_kind = ufs_pkg::KindEnd;
          cmd.r0_byte = 8'd0;
          phase_d     = PhBetween;
        end else begin
          cmd.r0_byte = {nib_q, ufs_pkg::hex_digit(data_byte_i)};
          phase_d     = PhValue;
        end
      end
      default: begin
        phase_d = PhDrop;
      end
    endcase

    if (end_of_data_i) begin
      cmd.end_v = (phase_d == PhName) || (phase_d == PhValue) ||
                  (phase_d == PhEsc1) || (phase_d == PhEsc2);
      phase_d   = PhBetween;
      nib_d     = 4'd0;
      opened_d  = 8'd0;
    end
  end

  assign push_o = accept & (cmd.r0_v | cmd.end_v);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhBetween;
      nib_q    <= 4'd0;
      opened_q <= 8'd0;
    end else if (accept) begin
      phase_q  <= phase_d;
      nib_q    <= nib_d;
      opened_q <= opened_d;
    end
  end

endmodule

// File: hdl/ufs_queue.sv
// ----------------------------------------------------------------------------
// ufs_queue: command queue
// Small register FIFO that decouples the classifier from the emitter.
// ----------------------------------------------------------------------------
module ufs_queue #(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ufs_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output ufs_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ufs_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/ufs_back.sv
// ----------------------------------------------------------------------------
// ufs_back: result emitter
// Expands each command into one or two result beats in an output register.
// ----------------------------------------------------------------------------
module ufs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ufs_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    kind_o,
  output logic [7:0]    out_byte_o,
  output logic [7:0]    field_index_o,
  output logic          run_last_o
);

  logic       valid_q, sub_q, sub_d;
  logic       load, emit, first;
  logic [1:0] kind_q;
  logic [7:0] byte_q, index_q;
  logic       last_q;

  assign load  = ~valid_q | ~out_stall_i;
  assign emit  = load & ~empty_i;
  // the first result is pending when it exists and has not gone out yet
  assign first = ~sub_q & cmd_i.r0_v;
  assign pop_o = emit & ~(first & cmd_i.end_v);

  always_comb begin
    sub_d = sub_q;
    if (emit) begin
      sub_d = first & cmd_i.end_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 1'b0;
    end else begin
      sub_q <= sub_d;
      if (load) begin
        valid_q <= ~empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      index_q <= cmd_i.index;
      if (first) begin
        kind_q <= cmd_i.r0_kind;
        byte_q <= cmd_i.r0_byte;
        last_q <= ~cmd_i.end_v;
      end else begin
        kind_q <= ufs_pkg::KindEnd;
        byte_q <= 8'd0;
        last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = kind_q;
  assign out_byte_o    = byte_q;
  assign field_index_o = index_q;
  assign run_last_o    = last_q;

endmodule

// File: hdl/ufs_checker.sv
// ----------------------------------------------------------------------------
// ufs_checker: port-level checks of the form splitter
// Watches the output channel and is bound to the top level.
// ----------------------------------------------------------------------------
module ufs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] out_byte_o,
  input logic [7:0] field_index_o,
  input logic       run_last_o
);

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
    $stable(out_byte_o) && $stable(field_index_o) && $stable(run_last_o))
    else $error("stalled output beat changed");

  // a field end carries no byte and closes its run
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ufs_pkg::KindEnd |-> out_byte_o == 8'd0 && run_last_o)
    else $error("field end with data or not last");

  // only a name or value byte can be followed by a second beat of its run
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> kind_o != ufs_pkg::KindEnd)
    else $error("non-last beat is a field end");

  // the second beat of a run is the field end, in the next cycle, same field
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o &&
    kind_o == ufs_pkg::KindEnd && field_index_o == $past(field_index_o))
    else $error("field end did not follow its byte");

endmodule

bind urlencoded_form_splitter_core ufs_checker u_ufs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .kind_o        (kind_o),
  .out_byte_o    (out_byte_o),
  .field_index_o (field_index_o),
  .run_last_o    (run_last_o)
);
